// ===== rtl/ffba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, status codes and controller/datapath link types for the
// first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Managed region: GRANULES and GRANULE_BYTES are powers of two.
    localparam int GRANULES      = 1024;
    localparam int GRANULE_BYTES = 8;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 14;
    localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
    localparam int NEED_W     = SIZE_W + 1 - GRAN_SHIFT;
    localparam int CMP_W      = ADDR_W + 1;

    // Bitmap storage: WORDS rows of WORD_BITS bits
    localparam int WORD_BITS = (GRANULES >= 64) ? 32 : GRANULES / 2;
    localparam int WORDS     = GRANULES / WORD_BITS;
    localparam int IDX_W     = $clog2(GRANULES);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WIDX_W    = IDX_W - BIT_W;
    localparam int RUN_W     = $clog2(GRANULES + WORD_BITS + 1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    scan;
        logic    free_range;
        logic    mark_init;
        logic    mark;
        logic    finish;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic alloc;
        logic too_big;
        logic fit;
        logic hit;
        logic scan_end;
        logic mark_end;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/first_fit_bitmap_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_core
// First-fit allocator over a used/free bitmap of 8-byte granules.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive i_kind/i_size_bytes/i_address with start; the transfer is
//   taken on a clock edge where start is high and busy is low.
//   Result: o_status/o_granted_address/o_granted_size are valid for exactly
//   one cycle with o_result_valid; there is no back-pressure, and busy is
//   already low in that cycle so the next request may be taken there.
//   Config: i_cfg_we/i_cfg_wdata write the region base; the user must write
//   it only while idle, as the block itself does not enforce this.
// Each request is checked first; a rejected one (zero size, free out of
//   range, oversize) ends there. An allocate then reads bitmap words from
//   word 0 until the run end (1..32 words), one 32-bit word per cycle, and
//   marks the words the run touches; a free marks its range. Marking is a
//   read-modify-write of one word per cycle. Items are handled one at a time.
// Reset: bitmap rows carry valid flags that reset clears, so every granule
//   reads free right after reset with no clearing pass; base resets to 0.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator_core
    import ffba_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [ADDR_W-1:0]  i_cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic [SIZE_W-1:0]  i_size_bytes,
    input  wire logic [ADDR_W-1:0]  i_address,
    output logic                    o_result_valid,
    output logic [1:0]              o_status,
    output logic [ADDR_W-1:0]       o_granted_address,
    output logic [SIZE_W-1:0]       o_granted_size
);

    t_cmd  cmd;
    t_stat stat;

    ffba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_stat         (stat),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd)
    );

    ffba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_kind            (i_kind),
        .i_size_bytes      (i_size_bytes),
        .i_address         (i_address),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_granted_size    (o_granted_size)
    );

endmodule
`default_nettype wire

// ===== rtl/ffba_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: request registers, bitmap memory with per-row valid
// flags, word-wide run search and read-modify-write range marking.
// ----------------------------------------------------------------------------
module ffba_dp
    import ffba_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [ADDR_W-1:0]   i_cfg_wdata,
    input  wire logic                i_kind,
    input  wire logic [SIZE_W-1:0]   i_size_bytes,
    input  wire logic [ADDR_W-1:0]   i_address,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic [1:0]               o_status,
    output logic [ADDR_W-1:0]        o_granted_address,
    output logic [SIZE_W-1:0]        o_granted_size
);

    // request
    logic [ADDR_W-1:0]   r_base_addr;
    logic                r_kind;
    logic [SIZE_W-1:0]   r_size;
    logic [NEED_W-1:0]   r_need;
    logic [ADDR_W-1:0]   r_offset;
    logic [IDX_W-1:0]    r_first;
    logic [IDX_W-1:0]    r_last;
    logic [RUN_W-1:0]    r_run;

    // memory access
    logic [WIDX_W:0]     r_rd_idx;
    logic                r_pend;
    logic [WIDX_W-1:0]   r_pend_idx;
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                r_rd_ok;
    logic [WORDS-1:0]    r_row_vld;

    // result
    t_status             r_status;
    logic [ADDR_W-1:0]   r_gaddr;
    logic [SIZE_W-1:0]   r_gsize;

    logic [WIDX_W-1:0]   rd_addr;
    logic                rd_issue;
    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wr_data;
    logic                wr_en;
    logic [BIT_W-1:0]    lo;
    logic [BIT_W-1:0]    hi;
    logic [WIDX_W-1:0]   first_word;
    logic [WIDX_W-1:0]   last_word;
    logic [ADDR_W-GRAN_SHIFT-1:0] free_first;
    logic [CMP_W-1:0]    free_end;
    logic [WORD_BITS-1:0] hit_vec;
    logic [RUN_W-1:0]    run_pos [WORD_BITS];
    logic [BIT_W-1:0]    hit_pos;
    logic                any_hit;
    logic [IDX_W-1:0]    hit_end;
    logic [CMP_W-1:0]    hit_start;
    logic [SIZE_W:0]     size_round;

    assign first_word = r_first[IDX_W-1 -: WIDX_W];
    assign last_word  = r_last[IDX_W-1 -: WIDX_W];
    assign rd_addr    = r_rd_idx[WIDX_W-1:0];
    assign word_cur   = r_rd_ok ? r_rdata : '0;
    assign size_round = {1'b0, i_size_bytes} + (SIZE_W+1)'(GRANULE_BYTES - 1);

    assign free_first = r_offset[ADDR_W-1:GRAN_SHIFT];
    assign free_end   = CMP_W'(free_first) + CMP_W'(r_need);

    always_comb begin
        rd_issue = 1'b0;
        if (i_cmd.scan) begin
            rd_issue = (r_rd_idx < (WIDX_W+1)'(WORDS));
        end else if (i_cmd.mark) begin
            rd_issue = (r_rd_idx <= {1'b0, last_word});
        end
    end

    // Run length ending at each bit of the current word; a used bit at or
    // below the position cuts the run carried in from earlier words.
    always_comb begin
        logic found;
        int   lastu;
        for (int j = 0; j < WORD_BITS; j++) begin
            found = 1'b0;
            lastu = 0;
            for (int k = 0; k < WORD_BITS; k++) begin
                if (k <= j && word_cur[k]) begin
                    found = 1'b1;
                    lastu = k;
                end
            end
            run_pos[j] = found ? RUN_W'(j - lastu) : r_run + RUN_W'(j + 1);
            hit_vec[j] = (CMP_W'(run_pos[j]) >= CMP_W'(r_need));
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_pos = BIT_W'(j);
            end
        end
    end

    assign any_hit   = |hit_vec;
    assign hit_end   = {r_pend_idx, hit_pos};
    assign hit_start = CMP_W'(hit_end) + CMP_W'(1) - CMP_W'(r_need);

    // Mark mask for the word in flight
    assign lo      = (r_pend_idx == first_word) ? r_first[BIT_W-1:0] : '0;
    assign hi      = (r_pend_idx == last_word) ? r_last[BIT_W-1:0] : '1;
    assign mask    = ({WORD_BITS{1'b1}} << lo) &
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
    assign wr_data = (r_kind == KIND_ALLOC) ? (word_cur | mask) : (word_cur & ~mask);
    assign wr_en   = i_cmd.mark && r_pend;

    always_comb begin
        o_stat          = '0;
        o_stat.zero     = (r_size == '0);
        o_stat.alloc    = (r_kind == KIND_ALLOC);
        o_stat.too_big  = (CMP_W'(r_need) > CMP_W'(GRANULES));
        o_stat.fit      = (free_end <= CMP_W'(GRANULES));
        o_stat.hit      = r_pend && any_hit;
        o_stat.scan_end = r_pend && !any_hit && (r_pend_idx == WIDX_W'(WORDS - 1));
        o_stat.mark_end = r_pend && (r_pend_idx == last_word);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pend_idx] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
        r_rd_ok <= r_row_vld[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld   <= '0;
            r_base_addr <= '0;
            r_pend      <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base_addr <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_row_vld[r_pend_idx] <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_rd_idx <= '0;
                r_pend   <= 1'b0;
            end else if (i_cmd.mark_init) begin
                r_rd_idx <= {1'b0, first_word};
                r_pend   <= 1'b0;
            end else if (i_cmd.scan || i_cmd.mark) begin
                r_pend <= rd_issue;
                if (rd_issue) begin
                    r_rd_idx <= r_rd_idx + (WIDX_W+1)'(1);
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= rd_addr;
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_size   <= i_size_bytes;
            r_need   <= NEED_W'(size_round >> GRAN_SHIFT);
            r_offset <= i_address - r_base_addr;
        end
        if (i_cmd.scan_init) begin
            r_run <= '0;
        end else if (i_cmd.scan && r_pend) begin
            r_run <= run_pos[WORD_BITS-1];
        end
        if (i_cmd.scan && r_pend && any_hit) begin
            r_first <= hit_start[IDX_W-1:0];
            r_last  <= hit_end;
        end else if (i_cmd.free_range) begin
            r_first <= free_first[IDX_W-1:0];
            r_last  <= IDX_W'(free_end - CMP_W'(1));
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            if (i_cmd.status == ST_DONE && r_kind == KIND_ALLOC) begin
                r_gaddr <= r_base_addr + (ADDR_W'(r_first) << GRAN_SHIFT);
                r_gsize <= r_size;
            end else begin
                r_gaddr <= '0;
                r_gsize <= '0;
            end
        end
    end

    assign o_status          = r_status;
    assign o_granted_address = r_gaddr;
    assign o_granted_size    = r_gsize;

`ifndef SYNTH
    a_hit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_pend && any_hit) |=> (r_first <= r_last))
        else $error("ffba_dp: found run ends before it starts");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_pend_idx >= first_word && r_pend_idx <= last_word))
        else $error("ffba_dp: bitmap write outside the marked range");

    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> !wr_en)
        else $error("ffba_dp: bitmap written during search");
`endif

endmodule
`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Allocator sequencer: request checks, bitmap search, range marking and
// result strobe.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_stat i_stat,
    output logic       busy,
    output logic       o_result_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SETUP,
        S_MARK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.zero) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD;
                end else if (i_stat.alloc) begin
                    if (i_stat.too_big) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_NO_ROOM;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else if (!i_stat.fit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD;
                end else begin
                    o_cmd.free_range = 1'b1;
                    n_state          = S_SETUP;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_SETUP;
                end else if (i_stat.scan_end) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NO_ROOM;
                end
            end
            S_SETUP: begin
                o_cmd.mark_init = 1'b1;
                n_state         = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.mark_end) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.finish) begin
            n_done  = 1'b1;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_done;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("ffba_ctrl: result strobe held for two cycles");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("ffba_ctrl: result strobe while a request is in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !r_done))
        else $error("ffba_ctrl: accepted transfer did not start a request");

    a_busy_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("ffba_ctrl: busy rose without a start");
`endif

endmodule
`default_nettype wire
